>>> src/fraction_reducer_defines.svh
// Assertion macros shared by the fraction reducer RTL.
// No dependencies; each macro expects clk and rst in scope.
`ifndef FRACTION_REDUCER_DEFINES_SVH
`define FRACTION_REDUCER_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define FRD_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, masked during reset.
`define FRD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> src/frd_pkg.sv
// Package for the fraction reducer: widths, microcode encoding and program ROM.
// No dependencies.
`timescale 1ns / 1ps

package frd_pkg;

  localparam int DATA_W = 32;
  localparam int MAG_W  = 31;
  localparam int STEP_W = 4;
  localparam int CNT_W  = 5;
  localparam int K_W    = 5;
  localparam int OP_W   = 4;
  localparam int COND_W = 4;
  localparam int GATE_W = 2;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_W - 1);

  // Datapath operations
  localparam logic [OP_W-1:0] OP_NOP         = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD        = 4'd1;
  localparam logic [OP_W-1:0] OP_COPY_B      = 4'd2;
  localparam logic [OP_W-1:0] OP_SHR_AB      = 4'd3;
  localparam logic [OP_W-1:0] OP_SHR_A       = 4'd4;
  localparam logic [OP_W-1:0] OP_SHR_B       = 4'd5;
  localparam logic [OP_W-1:0] OP_SUBSWAP     = 4'd6;
  localparam logic [OP_W-1:0] OP_GCD_DONE    = 4'd7;
  localparam logic [OP_W-1:0] OP_DIV_N       = 4'd8;
  localparam logic [OP_W-1:0] OP_DIV_STEP    = 4'd9;
  localparam logic [OP_W-1:0] OP_DIV_D       = 4'd10;
  localparam logic [OP_W-1:0] OP_WRITE       = 4'd11;
  localparam logic [OP_W-1:0] OP_WRITE_UNDEF = 4'd12;

  // Jump conditions
  localparam logic [COND_W-1:0] C_NEVER     = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS    = 4'd1;
  localparam logic [COND_W-1:0] C_NO_INPUT  = 4'd2;
  localparam logic [COND_W-1:0] C_DEN_ZERO  = 4'd3;
  localparam logic [COND_W-1:0] C_A_ZERO    = 4'd4;
  localparam logic [COND_W-1:0] C_BOTH_EVEN = 4'd5;
  localparam logic [COND_W-1:0] C_A_EVEN    = 4'd6;
  localparam logic [COND_W-1:0] C_B_EVEN    = 4'd7;
  localparam logic [COND_W-1:0] C_B_NZ      = 4'd8;
  localparam logic [COND_W-1:0] C_DIV_MORE  = 4'd9;
  localparam logic [COND_W-1:0] C_OUT_BUSY  = 4'd10;

  // When the step's operation fires
  localparam logic [GATE_W-1:0] G_ALWAYS    = 2'd0;
  localparam logic [GATE_W-1:0] G_TAKEN     = 2'd1;
  localparam logic [GATE_W-1:0] G_NOT_TAKEN = 2'd2;

  // Program labels
  localparam logic [STEP_W-1:0] S_LOAD      = 4'd0;
  localparam logic [STEP_W-1:0] S_CHK_DEN   = 4'd1;
  localparam logic [STEP_W-1:0] S_CHK_A     = 4'd2;
  localparam logic [STEP_W-1:0] S_SHR_AB    = 4'd3;
  localparam logic [STEP_W-1:0] S_SHR_A     = 4'd4;
  localparam logic [STEP_W-1:0] S_SHR_B     = 4'd5;
  localparam logic [STEP_W-1:0] S_SUBSWAP   = 4'd6;
  localparam logic [STEP_W-1:0] S_CHK_B     = 4'd7;
  localparam logic [STEP_W-1:0] S_GCD_DONE  = 4'd8;
  localparam logic [STEP_W-1:0] S_DIV_N     = 4'd9;
  localparam logic [STEP_W-1:0] S_DIV_N_LP  = 4'd10;
  localparam logic [STEP_W-1:0] S_DIV_D     = 4'd11;
  localparam logic [STEP_W-1:0] S_DIV_D_LP  = 4'd12;
  localparam logic [STEP_W-1:0] S_WRITE     = 4'd13;
  localparam logic [STEP_W-1:0] S_UNDEF     = 4'd14;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
    logic [GATE_W-1:0] gate;
    logic              last;
  } uword_t;

  typedef struct packed {
    logic den_zero;
    logic a_zero;
    logic both_even;
    logic a_even;
    logic b_even;
    logic b_nz;
    logic div_more;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            idle;
  } ctrl_t;

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      S_LOAD:     w = '{OP_LOAD,        C_NO_INPUT,  S_LOAD,     G_NOT_TAKEN, 1'b0};
      S_CHK_DEN:  w = '{OP_NOP,         C_DEN_ZERO,  S_UNDEF,    G_ALWAYS,    1'b0};
      S_CHK_A:    w = '{OP_COPY_B,      C_A_ZERO,    S_GCD_DONE, G_TAKEN,     1'b0};
      S_SHR_AB:   w = '{OP_SHR_AB,      C_BOTH_EVEN, S_SHR_AB,   G_TAKEN,     1'b0};
      S_SHR_A:    w = '{OP_SHR_A,       C_A_EVEN,    S_SHR_A,    G_TAKEN,     1'b0};
      S_SHR_B:    w = '{OP_SHR_B,       C_B_EVEN,    S_SHR_B,    G_TAKEN,     1'b0};
      S_SUBSWAP:  w = '{OP_SUBSWAP,     C_NEVER,     S_LOAD,     G_ALWAYS,    1'b0};
      S_CHK_B:    w = '{OP_NOP,         C_B_NZ,      S_SHR_B,    G_ALWAYS,    1'b0};
      S_GCD_DONE: w = '{OP_GCD_DONE,    C_NEVER,     S_LOAD,     G_ALWAYS,    1'b0};
      S_DIV_N:    w = '{OP_DIV_N,       C_NEVER,     S_LOAD,     G_ALWAYS,    1'b0};
      S_DIV_N_LP: w = '{OP_DIV_STEP,    C_DIV_MORE,  S_DIV_N_LP, G_ALWAYS,    1'b0};
      S_DIV_D:    w = '{OP_DIV_D,       C_NEVER,     S_LOAD,     G_ALWAYS,    1'b0};
      S_DIV_D_LP: w = '{OP_DIV_STEP,    C_DIV_MORE,  S_DIV_D_LP, G_ALWAYS,    1'b0};
      S_WRITE:    w = '{OP_WRITE,       C_OUT_BUSY,  S_WRITE,    G_NOT_TAKEN, 1'b1};
      S_UNDEF:    w = '{OP_WRITE_UNDEF, C_OUT_BUSY,  S_UNDEF,    G_NOT_TAKEN, 1'b1};
      default:    w = '{OP_NOP,         C_NEVER,     S_LOAD,     G_ALWAYS,    1'b1};
    endcase
    return w;
  endfunction

endpackage

>>> src/frd_sequencer.sv
// Microcode sequencer: step counter, program ROM lookup and jump logic.
// Depends on frd_pkg.
`timescale 1ns / 1ps

module frd_sequencer import frd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output ctrl_t   ctrl
);

  logic [STEP_W-1:0] step, step_next;
  uword_t            uw;
  logic              taken;
  logic              run;

  always_comb begin
    uw = ucode(step);
    case (uw.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_INPUT:  taken = !in_valid;
      C_DEN_ZERO:  taken = status.den_zero;
      C_A_ZERO:    taken = status.a_zero;
      C_BOTH_EVEN: taken = status.both_even;
      C_A_EVEN:    taken = status.a_even;
      C_B_EVEN:    taken = status.b_even;
      C_B_NZ:      taken = status.b_nz;
      C_DIV_MORE:  taken = status.div_more;
      C_OUT_BUSY:  taken = status.out_busy;
      default:     taken = 1'b0;
    endcase

    case (uw.gate)
      G_ALWAYS:    run = 1'b1;
      G_TAKEN:     run = taken;
      G_NOT_TAKEN: run = !taken;
      default:     run = 1'b0;
    endcase

    ctrl.op   = run ? uw.op : OP_NOP;
    ctrl.idle = (step == S_LOAD);

    priority if (taken) begin
      step_next = uw.target;
    end else if (uw.last) begin
      step_next = S_LOAD;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_LOAD;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> src/frd_datapath.sv
// Datapath of the fraction reducer: GCD registers, shared restoring divider,
// sign fixup and the output register. Depends on frd_pkg.
`timescale 1ns / 1ps

module frd_datapath import frd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_t                    ctrl,
  input  logic signed [DATA_W-1:0] numerator_in,
  input  logic signed [DATA_W-1:0] denominator_in,
  input  logic                     out_stall,
  output status_t                  status,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] numerator_out,
  output logic        [MAG_W-1:0]  denominator_out,
  output logic                     is_whole,
  output logic                     is_undefined
);

  logic [MAG_W-1:0] a, b, g, nm, dm, q, r, qn;
  logic [K_W-1:0]   k;
  logic [CNT_W-1:0] cnt;
  logic             nneg, dneg;

  logic [MAG_W-1:0]  num_mag_in, den_mag_in;
  logic [MAG_W:0]    rs, diff;
  logic              ge;
  logic [MAG_W-1:0]  q_step, r_step;
  logic [DATA_W-1:0] qn_ext, num_res;

  // Magnitude of a two's complement word; the most negative value clamps.
  function automatic logic [MAG_W-1:0] sat_mag(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] m;
    m = v[DATA_W-1] ? (~v + 1'b1) : v;
    return m[DATA_W-1] ? {MAG_W{1'b1}} : m[MAG_W-1:0];
  endfunction

  always_comb begin
    num_mag_in = sat_mag(numerator_in);
    den_mag_in = sat_mag(denominator_in);

    // one restoring division step: shift in the next dividend bit
    rs     = {r, q[MAG_W-1]};
    ge     = (rs >= {1'b0, g});
    diff   = rs - {1'b0, g};
    r_step = ge ? diff[MAG_W-1:0] : rs[MAG_W-1:0];
    q_step = {q[MAG_W-2:0], ge};

    qn_ext  = {1'b0, qn};
    num_res = ((nneg ^ dneg) && (qn != '0)) ? (~qn_ext + 1'b1) : qn_ext;

    status.den_zero  = (dm == '0);
    status.a_zero    = (a == '0);
    status.both_even = !a[0] && !b[0];
    status.a_even    = !a[0];
    status.b_even    = !b[0];
    status.b_nz      = (b != '0);
    status.div_more  = (cnt != DIV_LAST);
    status.out_busy  = out_valid && out_stall;
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        a    <= num_mag_in;
        b    <= den_mag_in;
        nm   <= num_mag_in;
        dm   <= den_mag_in;
        nneg <= numerator_in[DATA_W-1];
        dneg <= denominator_in[DATA_W-1];
        k    <= '0;
      end
      OP_COPY_B: a <= b;
      OP_SHR_AB: begin
        a <= a >> 1;
        b <= b >> 1;
        k <= k + 1'b1;
      end
      OP_SHR_A: a <= a >> 1;
      OP_SHR_B: b <= b >> 1;
      OP_SUBSWAP: begin
        // keep the smaller odd value in a, the difference in b
        if (a > b) begin
          a <= b;
          b <= a - b;
        end else begin
          b <= b - a;
        end
      end
      OP_GCD_DONE: g <= a << k;
      OP_DIV_N: begin
        q   <= nm;
        r   <= '0;
        cnt <= '0;
      end
      OP_DIV_STEP: begin
        q   <= q_step;
        r   <= r_step;
        cnt <= cnt + 1'b1;
      end
      OP_DIV_D: begin
        qn  <= q;
        q   <= dm;
        r   <= '0;
        cnt <= '0;
      end
      OP_WRITE: begin
        numerator_out   <= num_res;
        denominator_out <= q;
        is_whole        <= (q == MAG_W'(1));
        is_undefined    <= 1'b0;
      end
      OP_WRITE_UNDEF: begin
        numerator_out   <= '0;
        denominator_out <= '0;
        is_whole        <= 1'b0;
        is_undefined    <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_WRITE || ctrl.op == OP_WRITE_UNDEF) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> src/fraction_reducer.sv
// Fraction reducer: reduces a signed fraction to lowest terms with a positive
// denominator. Top level over frd_sequencer and frd_datapath; uses frd_pkg.
//
// Input channel (in_valid / in_stall): numerator_in, denominator_in. Output
// channel (out_valid / out_stall): numerator_out, denominator_out, is_whole,
// is_undefined. A transfer happens on a rising edge with valid high and stall low.
// One item is worked at a time. in_stall is low only while the sequencer
// sits on its load step; an item is taken there in the cycle it shows up.
// The time from input transfer to out_valid depends on the item: a zero
// denominator goes straight to the undefined write, a zero numerator skips
// the GCD loop, and otherwise it grows with the halvings and subtract rounds of
// the binary GCD loop; the two 31-step restoring divisions share one subtractor.
// The next item is taken in the cycle after the result is written.
// The result sits in an output register, so a new item is taken and worked
// while the previous result waits; the finished item then holds on its write
// step until the output register frees up.
// Reset (rst, synchronous) returns the sequencer to the load step and drops
// out_valid; no clearing pass is needed.
`timescale 1ns / 1ps
`include "fraction_reducer_defines.svh"

module fraction_reducer import frd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] numerator_in,
  input  logic signed [DATA_W-1:0] denominator_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] numerator_out,
  output logic        [MAG_W-1:0]  denominator_out,
  output logic                     is_whole,
  output logic                     is_undefined
);

  ctrl_t   ctrl;
  status_t status;

  assign in_stall = !ctrl.idle;

  frd_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  frd_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .numerator_in    (numerator_in),
    .denominator_in  (denominator_in),
    .out_stall       (out_stall),
    .status          (status),
    .out_valid       (out_valid),
    .numerator_out   (numerator_out),
    .denominator_out (denominator_out),
    .is_whole        (is_whole),
    .is_undefined    (is_undefined)
  );

  // an accepted item keeps the input closed while it is worked
  `FRD_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input open after transfer")
  `FRD_ASSERT_IMPL(a_undef_zero, out_valid && is_undefined, numerator_out == '0 && denominator_out == '0, "undefined result not zeroed")
  `FRD_ASSERT_IMPL(a_den_pos, out_valid && !is_undefined, denominator_out != '0, "zero denominator on defined result")
  `FRD_ASSERT_IMPL(a_whole_flag, out_valid, is_whole == (denominator_out == MAG_W'(1)), "whole flag mismatch")

endmodule

>>> tb/sv/fraction_reducer_test.sv
`timescale 1ns / 1ps
// Testbench for fraction_reducer: a directed table, then random fractions with
// random idling on both channels. Depends on frd_pkg for the port widths.

module fraction_reducer_test;
  import frd_pkg::*;

  localparam int RANDOM_ITEMS = 750;
  localparam int LONG_HOLD    = 1500;
  localparam int DRAIN_CYCLES = 400;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int PRINT_LIMIT  = 100;

  localparam logic signed [DATA_W-1:0] POS_LIMIT = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] NEG_LIMIT = 32'sh8000_0001;
  localparam logic signed [DATA_W-1:0] MINUS_ONE = -32'sd1;
  localparam logic        [MAG_W-1:0]  DEN_LIMIT = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [DATA_W-1:0] num;
    logic        [MAG_W-1:0]  den;
    logic                     whole;
    logic                     undef;
  } fraction_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] num;
    logic signed [DATA_W-1:0] den;
    logic                     known;
    fraction_t                want;
  } table_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] numerator_in = '0;
  logic signed [DATA_W-1:0] denominator_in = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] numerator_out;
  logic        [MAG_W-1:0]  denominator_out;
  logic                     is_whole;
  logic                     is_undefined;

  fraction_t reduced_queue[$];
  int        errors = 0;
  int        items_sent = 0;
  int        results_seen = 0;
  int        undefined_seen = 0;
  int        whole_seen = 0;
  int        holds_done = 0;
  int        cycle_count = 0;
  bit        hold_req = 1'b0;
  bit        no_idle = 1'b0;

  fraction_reducer DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .numerator_in   (numerator_in),
    .denominator_in (denominator_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .numerator_out  (numerator_out),
    .denominator_out(denominator_out),
    .is_whole       (is_whole),
    .is_undefined   (is_undefined)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reduce to lowest terms with Euclid; the sign moves onto the numerator.
  function automatic fraction_t reduce_fraction(logic signed [DATA_W-1:0] num,
                                                logic signed [DATA_W-1:0] den);
    fraction_t         r;
    logic              nneg;
    logic              dneg;
    logic [DATA_W-1:0] nmag;
    logic [DATA_W-1:0] dmag;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] qn;
    logic [DATA_W-1:0] qd;
    r    = '0;
    nneg = num[DATA_W-1];
    dneg = den[DATA_W-1];
    nmag = nneg ? 32'd0 - num : num;
    dmag = dneg ? 32'd0 - den : den;
    if (nmag > 32'h7FFF_FFFF) nmag = 32'h7FFF_FFFF;
    if (dmag > 32'h7FFF_FFFF) dmag = 32'h7FFF_FFFF;
    if (dmag == 0) begin
      r.undef = 1'b1;
      return r;
    end
    x = nmag;
    y = dmag;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    qn      = nmag / x;
    qd      = dmag / x;
    r.num   = (nneg != dneg) ? 32'd0 - qn : qn;
    r.den   = qd[MAG_W-1:0];
    r.whole = (qd == 1);
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [DATA_W-1:0] rand_mag(int unsigned bits);
    return $urandom & ((32'h1 << bits) - 1);
  endfunction

  function automatic logic signed [DATA_W-1:0] apply_sign(logic [DATA_W-1:0] mag);
    return ($urandom_range(0, 1) == 1) ? 32'd0 - mag : mag;
  endfunction

  function automatic logic signed [DATA_W-1:0] full_value();
    logic [DATA_W-1:0] v;
    v = $urandom;
    if (v == 32'h8000_0000) v = NEG_LIMIT;
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] edge_value();
    case ($urandom_range(0, 5))
      0:       return POS_LIMIT;
      1:       return NEG_LIMIT;
      2:       return 32'sd1;
      3:       return MINUS_ONE;
      4:       return 32'sd0;
      default: return POS_LIMIT - 1;
    endcase
  endfunction

  task automatic pick_fraction(output logic signed [DATA_W-1:0] num,
                               output logic signed [DATA_W-1:0] den);
    int unsigned       gb;
    int unsigned       sh;
    logic [DATA_W-1:0] g;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        num = full_value();
        den = full_value();
      end
      3, 4: begin
        // shared factor, so the division really does something
        gb = $urandom_range(1, 15);
        g  = rand_mag(gb);
        if (g == 0) g = 1;
        a  = rand_mag($urandom_range(1, 30 - gb));
        b  = rand_mag($urandom_range(1, 30 - gb));
        if (b == 0) b = 1;
        num = apply_sign(a * g);
        den = apply_sign(b * g);
      end
      5: begin
        num = $urandom_range(0, 40);
        num = num - 20;
        den = $urandom_range(0, 40);
        den = den - 20;
      end
      6: begin
        sh  = $urandom_range(0, 15);
        num = apply_sign(rand_mag($urandom_range(1, 15)) << sh);
        sh  = $urandom_range(0, 15);
        den = apply_sign(rand_mag($urandom_range(1, 15)) << sh);
      end
      7: begin
        num = full_value();
        den = 32'sd0;
      end
      8: begin
        num = 32'sd0;
        den = ($urandom_range(0, 1) == 1) ? full_value() : edge_value();
      end
      default: begin
        if ($urandom_range(0, 1) == 1) begin
          num = edge_value();
          den = full_value();
        end else begin
          num = full_value();
          den = edge_value();
        end
      end
    endcase
  endtask

  task automatic report_error(string msg);
    if (errors < PRINT_LIMIT) $display("ERROR at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  // Hold the payload until the transfer, then queue what it must reduce to.
  task automatic offer_fraction(logic signed [DATA_W-1:0] num,
                                logic signed [DATA_W-1:0] den, fraction_t want);
    int gap;
    gap = no_idle ? 0 : idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    numerator_in   <= num;
    denominator_in <= den;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reduced_queue.push_back(want);
    items_sent++;
  endtask

  task automatic wait_drained();
    while (reduced_queue.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    fraction_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (reduced_queue.size() == 0) begin
        report_error($sformatf("result %0d/%0d with nothing expected",
                               numerator_out, denominator_out));
      end else begin
        want = reduced_queue.pop_front();
        if (numerator_out !== want.num)
          report_error($sformatf("result %0d numerator: expected %0d, got %0d",
                                 results_seen, want.num, numerator_out));
        if (denominator_out !== want.den)
          report_error($sformatf("result %0d denominator: expected %0d, got %0d",
                                 results_seen, want.den, denominator_out));
        if (is_whole !== want.whole)
          report_error($sformatf("result %0d is_whole: expected %b, got %b",
                                 results_seen, want.whole, is_whole));
        if (is_undefined !== want.undef)
          report_error($sformatf("result %0d is_undefined: expected %b, got %b",
                                 results_seen, want.undef, is_undefined));
        if (want.undef) undefined_seen++;
        if (want.whole) whole_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, reduced_queue.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Output side: alternate ready runs and stalls; a long hold on request.
  initial begin : receiver
    int   span;
    logic level;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        level    = 1'b1;
        span     = LONG_HOLD;
        holds_done++;
      end else if (no_idle) begin
        level = 1'b0;
        span  = 1;
      end else if (out_stall) begin
        level = 1'b0;
        span  = $urandom_range(1, 24);
      end else begin
        level = 1'b1;
        span  = idle_span();
        if (span == 0) begin
          level = 1'b0;
          span  = 1;
        end
      end
      out_stall <= level;
      repeat (span) @(posedge clk);
    end
  end

  initial begin : stimulus
    table_row_t               rows [24];
    fraction_t                want;
    logic signed [DATA_W-1:0] num;
    logic signed [DATA_W-1:0] den;

    rows = '{
      '{32'sd5,     32'sd0,     1'b1, '{32'sd0,    31'd0,     1'b0, 1'b1}},
      '{32'sd0,     32'sd0,     1'b1, '{32'sd0,    31'd0,     1'b0, 1'b1}},
      '{NEG_LIMIT,  32'sd0,     1'b1, '{32'sd0,    31'd0,     1'b0, 1'b1}},
      '{POS_LIMIT,  32'sd0,     1'b1, '{32'sd0,    31'd0,     1'b0, 1'b1}},
      '{32'sd0,     32'sd7,     1'b1, '{32'sd0,    31'd1,     1'b1, 1'b0}},
      '{32'sd0,     -32'sd5,    1'b1, '{32'sd0,    31'd1,     1'b1, 1'b0}},
      '{32'sd0,     NEG_LIMIT,  1'b1, '{32'sd0,    31'd1,     1'b1, 1'b0}},
      '{POS_LIMIT,  32'sd1,     1'b1, '{POS_LIMIT, 31'd1,     1'b1, 1'b0}},
      '{NEG_LIMIT,  32'sd1,     1'b1, '{NEG_LIMIT, 31'd1,     1'b1, 1'b0}},
      '{POS_LIMIT,  MINUS_ONE,  1'b1, '{NEG_LIMIT, 31'd1,     1'b1, 1'b0}},
      '{32'sd1,     POS_LIMIT,  1'b1, '{32'sd1,    DEN_LIMIT, 1'b0, 1'b0}},
      '{MINUS_ONE,  POS_LIMIT,  1'b1, '{MINUS_ONE, DEN_LIMIT, 1'b0, 1'b0}},
      '{32'sd1,     NEG_LIMIT,  1'b1, '{MINUS_ONE, DEN_LIMIT, 1'b0, 1'b0}},
      '{POS_LIMIT,  POS_LIMIT,  1'b1, '{32'sd1,    31'd1,     1'b1, 1'b0}},
      '{NEG_LIMIT,  NEG_LIMIT,  1'b1, '{32'sd1,    31'd1,     1'b1, 1'b0}},
      '{POS_LIMIT,  NEG_LIMIT,  1'b1, '{MINUS_ONE, 31'd1,     1'b1, 1'b0}},
      '{32'sd12,    32'sd18,    1'b0, '0},
      '{-32'sd6,    32'sd4,     1'b0, '0},
      '{32'sd6,     -32'sd4,    1'b0, '0},
      '{-32'sd6,    -32'sd4,    1'b0, '0},
      '{32'sh4000_0000, 32'sh0010_0000, 1'b0, '0},
      '{POS_LIMIT,  POS_LIMIT - 1, 1'b0, '0},
      '{32'sh3FFF_FFFF, -32'sd3, 1'b0, '0},
      '{-32'sd45,   -32'sd1,    1'b0, '0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      want = rows[i].known ? rows[i].want : reduce_fraction(rows[i].num, rows[i].den);
      offer_fraction(rows[i].num, rows[i].den, want);
    end
    in_valid <= 1'b0;
    wait_drained();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 150) begin
        // sender pauses until the block has emptied out
        in_valid <= 1'b0;
        wait_drained();
      end
      if (k == 300) hold_req = 1'b1;
      // back-to-back stretches: during the long hold, and one free-running run
      no_idle = (k >= 300 && k < 320) || (k >= 500 && k < 580);
      pick_fraction(num, den);
      offer_fraction(num, den, reduce_fraction(num, den));
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Reduced %0d fractions (%0d directed), %0d undefined and %0d whole,",
             items_sent, $size(rows), undefined_seen, whole_seen);
    $display("with random idling on both sides and %0d long output hold(s); %0d errors",
             holds_done, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/frd_pkg.sv
src/frd_sequencer.sv
src/frd_datapath.sv
src/fraction_reducer.sv
tb/sv/fraction_reducer_test.sv
